>>> rtl/core/quarter_rate_iq_detector_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the quarter-rate I/Q detector
// Shared helpers for the concurrent checks; sampled on the rising clock edge
// and disabled while the synchronous active-low reset is asserted.
// ---------------------------------------------------------------------------
`ifndef QUARTER_RATE_IQ_DETECTOR_ASSERT_SVH
`define QUARTER_RATE_IQ_DETECTOR_ASSERT_SVH

// Consequent is checked in the same cycle as the antecedent.
`define QRIQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent is checked in the cycle after the antecedent.
`define QRIQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/qriq_pkg.sv
// ---------------------------------------------------------------------------
// qriq_pkg
// Types, constants and small helper functions of the quarter-rate I/Q
// detector.
// ---------------------------------------------------------------------------
package qriq_pkg;

    // Field widths.
    localparam int SAMPLE_W   = 16;
    localparam int TERM_W     = 17;
    localparam int SUM_W      = 23;
    localparam int COUNT_W    = 7;
    localparam int TIMEBASE_W = 8;
    localparam int EXT_W      = 32;

    // Default configuration.
    localparam int DEF_WINDOW_DEPTH  = 64;
    localparam int DEF_FRAME_SAMPLES = 256;

    // Group and timebase constants.
    localparam int                    GROUP_LEN        = 4;
    localparam logic [1:0]            LAST_PHASE       = 2'd3;
    localparam logic [TIMEBASE_W-1:0] GROUP_START_BITS = 8'hFC;

    // Output saturation limits.
    localparam logic signed [EXT_W-1:0] SUM_MAX   = 32'sd4194303;
    localparam logic signed [EXT_W-1:0] SUM_MIN   = -32'sd4194304;
    localparam logic [EXT_W-1:0]        COUNT_MAX = 32'd127;

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // One command word passed from the front to the back.
    typedef struct packed {
        logic                     restart;
        logic signed [TERM_W-1:0] sin_term;
        logic signed [TERM_W-1:0] cos_term;
    } t_group_cmd;

    // One window entry, both terms side by side.
    typedef struct packed {
        logic signed [TERM_W-1:0] sin_term;
        logic signed [TERM_W-1:0] cos_term;
    } t_window_entry;

    // Clamp an exact total into the signed output range.
    function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [EXT_W-1:0] v);
        logic signed [EXT_W-1:0] c;
        c = v;
        if (v > SUM_MAX) begin
            c = SUM_MAX;
        end else if (v < SUM_MIN) begin
            c = SUM_MIN;
        end
        return c[SUM_W-1:0];
    endfunction

    // Clamp the fill count into the output field.
    function automatic logic [COUNT_W-1:0] sat_count(input logic [EXT_W-1:0] v);
        logic [EXT_W-1:0] c;
        c = (v > COUNT_MAX) ? COUNT_MAX : v;
        return c[COUNT_W-1:0];
    endfunction

    // Start of the next group within the frame, kept to the field's bits.
    function automatic logic [TIMEBASE_W-1:0] make_timebase(input logic [EXT_W-1:0] gp);
        logic [EXT_W-1:0] t;
        t = gp * EXT_W'(GROUP_LEN);
        return t[TIMEBASE_W-1:0] & GROUP_START_BITS;
    endfunction

endpackage

>>> rtl/core/qriq_if.sv
// ---------------------------------------------------------------------------
// qriq_in_if / qriq_out_if
// Valid/ready channels of the detector: sample words in, result words out.
// ---------------------------------------------------------------------------
interface qriq_in_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [qriq_pkg::SAMPLE_W-1:0]    sample;
    logic                                    restart;

    modport source (output valid, output sample, output restart, input ready);
    modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface qriq_out_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [qriq_pkg::SUM_W-1:0]       sin_sum;
    logic signed [qriq_pkg::SUM_W-1:0]       cos_sum;
    logic [qriq_pkg::COUNT_W-1:0]            period_count;
    logic [qriq_pkg::TIMEBASE_W-1:0]         timebase;

    modport source (output valid, output sin_sum, output cos_sum, output period_count,
                    output timebase, input ready);
    modport sink   (input valid, input sin_sum, input cos_sum, input period_count,
                    input timebase, output ready);
endinterface

>>> rtl/core/quarter_rate_iq_detector.sv
// ---------------------------------------------------------------------------
// quarter_rate_iq_detector
// Quadrature detector for a tone at a quarter of the sample rate, with
// sliding-window sums of the sine and cosine terms.
//
//   Channel | Dir | Word fields
//   --------+-----+----------------------------------------------
//   i_in    | in  | sample (16, signed), restart (1)
//   o_out   | out | sin_sum, cos_sum (23, signed), period_count (7),
//           |     | timebase (8)
//
// One sample word is taken every cycle while the command queue has room.
// Every fourth word (and every restart word) sends a command to the back,
// which handles a group as a window RAM read, then the update and the
// RAM write. A result word waits in the output register; while it
// stalls, up to four commands gather in the queue before i_in.ready drops.
// Reset is synchronous and active low; the window RAM needs no clearing.
// ---------------------------------------------------------------------------
module quarter_rate_iq_detector #(
    parameter int WINDOW_DEPTH  = qriq_pkg::DEF_WINDOW_DEPTH,
    parameter int FRAME_SAMPLES = qriq_pkg::DEF_FRAME_SAMPLES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qriq_in_if.sink     i_in,
    qriq_out_if.source  o_out
);

    qriq_pkg::t_group_cmd push_cmd;
    qriq_pkg::t_group_cmd head_cmd;
    logic                 push;
    logic                 pop;
    logic                 q_full;
    logic                 q_empty;

    // Front: sample intake and term forming.
    qriq_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (i_in),
        .i_full (q_full),
        .o_push (push),
        .o_cmd  (push_cmd)
    );

    // Command queue.
    qriq_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (push_cmd),
        .i_pop  (pop),
        .o_cmd  (head_cmd),
        .o_full (q_full),
        .o_empty(q_empty)
    );

    // Back: window sums and result words.
    qriq_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .FRAME_SAMPLES(FRAME_SAMPLES)
    ) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (head_cmd),
        .i_empty(q_empty),
        .o_pop  (pop),
        .o_out  (o_out)
    );

endmodule

>>> rtl/core/qriq_ram.sv
// ---------------------------------------------------------------------------
// qriq_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ---------------------------------------------------------------------------
module qriq_ram #(
    parameter int WIDTH  = 34,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/qriq_front.sv
// ---------------------------------------------------------------------------
// qriq_front
// Takes sample words, holds the first three samples of each group and forms
// the sine and cosine terms on the fourth. Restart words become commands.
// ---------------------------------------------------------------------------
module qriq_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    qriq_in_if.sink               i_in,
    input  logic                  i_full,
    output logic                  o_push,
    output qriq_pkg::t_group_cmd  o_cmd
);

    logic [1:0]                             r_phase;
    logic [1:0]                             n_phase;
    logic signed [qriq_pkg::SAMPLE_W-1:0]   r_held [3];
    logic                                   accept;
    logic signed [qriq_pkg::TERM_W-1:0]     sin_term;
    logic signed [qriq_pkg::TERM_W-1:0]     cos_term;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;

    // Terms of the group, kept at full precision.
    assign sin_term = qriq_pkg::TERM_W'(r_held[1]) - qriq_pkg::TERM_W'(i_in.sample);
    assign cos_term = qriq_pkg::TERM_W'(r_held[0]) - qriq_pkg::TERM_W'(r_held[2]);

    // A command goes out on a restart word or on the last sample of a group.
    always_comb begin
        o_push         = accept && (i_in.restart || r_phase == qriq_pkg::LAST_PHASE);
        o_cmd.restart  = i_in.restart;
        o_cmd.sin_term = sin_term;
        o_cmd.cos_term = cos_term;
        n_phase        = r_phase;
        if (accept) begin
            if (i_in.restart || r_phase == qriq_pkg::LAST_PHASE) begin
                n_phase = 2'd0;
            end else begin
                n_phase = r_phase + 2'd1;
            end
        end
    end

    // Phase counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
        end else begin
            r_phase <= n_phase;
        end
    end

    // Sample holding registers.
    always_ff @(posedge i_clk) begin
        if (accept && !i_in.restart && r_phase != qriq_pkg::LAST_PHASE) begin
            r_held[r_phase] <= i_in.sample;
        end
    end

endmodule

>>> rtl/core/qriq_queue.sv
// ---------------------------------------------------------------------------
// qriq_queue
// Short first-in first-out queue of commands between the front and the back.
// ---------------------------------------------------------------------------
module qriq_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  qriq_pkg::t_group_cmd  i_cmd,
    input  logic                  i_pop,
    output qriq_pkg::t_group_cmd  o_cmd,
    output logic                  o_full,
    output logic                  o_empty
);

    qriq_pkg::t_group_cmd           r_mem [qriq_pkg::QUEUE_DEPTH];
    logic [qriq_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [qriq_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [qriq_pkg::QPTR_W:0]      r_count;
    logic                           do_push;
    logic                           do_pop;

    assign o_full  = (r_count == (qriq_pkg::QPTR_W + 1)'(qriq_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

>>> rtl/core/qriq_back.sv
// ---------------------------------------------------------------------------
// qriq_back
// Carries out commands: updates the sliding-window sums through the window
// RAM, advances the group position and presents one result word per group.
// ---------------------------------------------------------------------------
module qriq_back #(
    parameter int WINDOW_DEPTH  = qriq_pkg::DEF_WINDOW_DEPTH,
    parameter int FRAME_SAMPLES = qriq_pkg::DEF_FRAME_SAMPLES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  qriq_pkg::t_group_cmd  i_cmd,
    input  logic                  i_empty,
    output logic                  o_pop,
    qriq_out_if.source            o_out
);

    localparam int TOTAL_W  = qriq_pkg::TERM_W + $clog2(WINDOW_DEPTH);
    localparam int PTR_W    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W   = $clog2(WINDOW_DEPTH + 1);
    localparam int GROUPS   = (FRAME_SAMPLES / 4 < 1) ? 1 : FRAME_SAMPLES / 4;
    localparam int GP_W     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int ENTRY_W  = $bits(qriq_pkg::t_window_entry);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_UPDATE = 1'b1;

    logic                                r_state;
    logic                                n_state;
    logic signed [qriq_pkg::TERM_W-1:0]  r_sin_term;
    logic signed [qriq_pkg::TERM_W-1:0]  r_cos_term;
    logic signed [TOTAL_W-1:0]           r_sin_total;
    logic signed [TOTAL_W-1:0]           r_cos_total;
    logic signed [TOTAL_W-1:0]           n_sin_total;
    logic signed [TOTAL_W-1:0]           n_cos_total;
    logic [PTR_W-1:0]                    r_ptr;
    logic [PTR_W-1:0]                    n_ptr;
    logic [FILL_W-1:0]                   r_fill;
    logic [FILL_W-1:0]                   n_fill;
    logic [GP_W-1:0]                     r_gp;
    logic [GP_W-1:0]                     n_gp;

    logic                                r_out_valid;
    logic signed [qriq_pkg::SUM_W-1:0]   r_sin_sum;
    logic signed [qriq_pkg::SUM_W-1:0]   r_cos_sum;
    logic [qriq_pkg::COUNT_W-1:0]        r_period_count;
    logic [qriq_pkg::TIMEBASE_W-1:0]     r_timebase;

    logic                                take_group;
    logic                                take_restart;
    logic                                finish;
    logic                                out_free;
    logic                                win_full;
    logic [ENTRY_W-1:0]                  rd_data;
    qriq_pkg::t_window_entry             old_entry;
    qriq_pkg::t_window_entry             new_entry;
    logic signed [qriq_pkg::TERM_W-1:0]  old_sin;
    logic signed [qriq_pkg::TERM_W-1:0]  old_cos;

    // Window RAM holding both terms of each group.
    qriq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (WINDOW_DEPTH),
        .ADDR_W(PTR_W)
    ) u_window (
        .i_clk    (i_clk),
        .i_wr_en  (finish),
        .i_wr_addr(r_ptr),
        .i_wr_data(new_entry),
        .i_rd_en  (take_group),
        .i_rd_addr(r_ptr),
        .o_rd_data(rd_data)
    );

    // Command intake and sequencing.
    assign out_free     = !r_out_valid || o_out.ready;
    assign take_restart = (r_state == ST_IDLE) && !i_empty && i_cmd.restart;
    assign take_group   = (r_state == ST_IDLE) && !i_empty && !i_cmd.restart;
    assign finish       = (r_state == ST_UPDATE) && out_free;
    assign o_pop        = take_restart || take_group;

    always_comb begin
        case (r_state)
            ST_IDLE:   n_state = take_group ? ST_UPDATE : ST_IDLE;
            ST_UPDATE: n_state = finish ? ST_IDLE : ST_UPDATE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Window update: drop the oldest term once full, add the new one.
    assign old_entry          = qriq_pkg::t_window_entry'(rd_data);
    assign win_full           = (r_fill == FILL_W'(WINDOW_DEPTH));
    assign old_sin            = win_full ? old_entry.sin_term : '0;
    assign old_cos            = win_full ? old_entry.cos_term : '0;
    assign new_entry.sin_term = r_sin_term;
    assign new_entry.cos_term = r_cos_term;

    always_comb begin
        n_sin_total = r_sin_total - TOTAL_W'(old_sin) + TOTAL_W'(r_sin_term);
        n_cos_total = r_cos_total - TOTAL_W'(old_cos) + TOTAL_W'(r_cos_term);
        n_fill      = win_full ? r_fill : r_fill + 1'b1;
        n_ptr       = (r_ptr == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : r_ptr + 1'b1;
        n_gp        = (r_gp == GP_W'(GROUPS - 1)) ? '0 : r_gp + 1'b1;
    end

    // Control state and running sums.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sin_total <= '0;
            r_cos_total <= '0;
            r_ptr       <= '0;
            r_fill      <= '0;
            r_gp        <= '0;
        end else begin
            r_state <= n_state;
            if (take_restart) begin
                r_sin_total <= '0;
                r_cos_total <= '0;
                r_ptr       <= '0;
                r_fill      <= '0;
                r_gp        <= '0;
            end else if (finish) begin
                r_sin_total <= n_sin_total;
                r_cos_total <= n_cos_total;
                r_ptr       <= n_ptr;
                r_fill      <= n_fill;
                r_gp        <= n_gp;
            end
        end
    end

    // Terms of the group under work.
    always_ff @(posedge i_clk) begin
        if (take_group) begin
            r_sin_term <= i_cmd.sin_term;
            r_cos_term <= i_cmd.cos_term;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_sin_sum      <= qriq_pkg::sat_sum(qriq_pkg::EXT_W'(n_sin_total));
            r_cos_sum      <= qriq_pkg::sat_sum(qriq_pkg::EXT_W'(n_cos_total));
            r_period_count <= qriq_pkg::sat_count(qriq_pkg::EXT_W'(n_fill));
            r_timebase     <= qriq_pkg::make_timebase(qriq_pkg::EXT_W'(n_gp));
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.sin_sum      = r_sin_sum;
    assign o_out.cos_sum      = r_cos_sum;
    assign o_out.period_count = r_period_count;
    assign o_out.timebase     = r_timebase;

endmodule

>>> rtl/core/qriq_checker.sv
// ---------------------------------------------------------------------------
// qriq_checker
// Port-level checks of the detector's result stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "quarter_rate_iq_detector_assert.svh"

module qriq_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_out_valid,
    input logic                                  i_out_ready,
    input logic signed [qriq_pkg::SUM_W-1:0]     i_sin_sum,
    input logic signed [qriq_pkg::SUM_W-1:0]     i_cos_sum,
    input logic [qriq_pkg::COUNT_W-1:0]          i_period_count,
    input logic [qriq_pkg::TIMEBASE_W-1:0]       i_timebase
);

    // A stalled result word keeps its contents.
    `QRIQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_sin_sum) && $stable(i_cos_sum) && $stable(i_period_count) && $stable(i_timebase), "stalled result word changed")

    // Every result covers at least one group and starts on a group boundary.
    `QRIQ_ASSERT_SAME(a_out_shape, i_clk, i_rst_n, i_out_valid, i_period_count != '0 && i_timebase[1:0] == 2'b00, "result word has empty window or odd timebase")

    // Consecutive results: the count grows by one, holds when full, or restarts at one.
    `QRIQ_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, i_out_valid && i_out_ready, !i_out_valid || i_period_count == $past(i_period_count) + 7'd1 || i_period_count == $past(i_period_count) || i_period_count == 7'd1, "period count stepped wrongly")

    // Consecutive results: the timebase moves one group on, wraps, or restarts.
    `QRIQ_ASSERT_NEXT(a_timebase_step, i_clk, i_rst_n, i_out_valid && i_out_ready, !i_out_valid || i_timebase == $past(i_timebase) + 8'd4 || i_timebase == 8'd0 || i_period_count == 7'd1, "timebase stepped wrongly")

endmodule

bind quarter_rate_iq_detector qriq_checker u_qriq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_sin_sum     (o_out.sin_sum),
    .i_cos_sum     (o_out.cos_sum),
    .i_period_count(o_out.period_count),
    .i_timebase    (o_out.timebase)
);
